FILE: rtl/rcfd_pkg.sv
// Shared types, codes and constants for the radio-control frame channel decoder.
`default_nettype none

package rcfd_pkg;

    // Output value width; the slot data is left-justified into this many bits.
    localparam int VALUE_BITS = 16;
    localparam int SLOTS      = 7;

    localparam logic [2:0]  LAST_SLOT  = 3'(SLOTS - 1);
    localparam logic [15:0] EMPTY_SLOT = 16'hffff;

    // Format codes.
    localparam logic [1:0] FMT_UNKNOWN = 2'd0;
    localparam logic [1:0] FMT_TEN     = 2'd1;
    localparam logic [1:0] FMT_ELEVEN  = 2'd2;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_CHANNELS = 2'd0;
    localparam logic [1:0] CFG_SNIFF_FRAMES = 2'd1;
    localparam logic [1:0] CFG_LOSS_TIMEOUT = 2'd2;

    localparam logic [4:0]  MAX_CHANNELS_RST = 5'd16;
    localparam logic [7:0]  SNIFF_FRAMES_RST = 8'd5;
    localparam logic [31:0] LOSS_TIMEOUT_RST = 32'd1000000;

    // A thirteen-channel count is reported as twelve.
    localparam logic [4:0] COUNT_ODD  = 5'd13;
    localparam logic [4:0] COUNT_SHOW = 5'd12;

    typedef struct packed {
        logic [15:0] slot_word;
        logic [2:0]  slot_index;
        logic [31:0] start_stamp;
    } t_in_item;

    typedef struct packed {
        logic        slot_valid;
        logic [3:0]  out_channel;
        logic [15:0] out_value;
        logic        frame_done;
        logic [4:0]  channel_count;
        logic [1:0]  format_state;
    } t_out_item;

    typedef struct packed {
        logic [4:0]  max_channels;
        logic [7:0]  sniff_frames;
        logic [31:0] loss_timeout_us;
    } t_cfg;

    // True when the mask is one of the known channel-number patterns.
    function automatic logic is_known_mask(input logic [15:0] m);
        logic hit;
        hit = (m == 16'h003f) || (m == 16'h007f) || (m == 16'h00ff) ||
              (m == 16'h01ff) || (m == 16'h03ff) || (m == 16'h1fff) ||
              (m == 16'h3fff);
        return hit;
    endfunction

endpackage

`default_nettype wire

FILE: rtl/rcfd_cfg_regs.sv
// Configuration register file of the frame channel decoder.
`default_nettype none

module rcfd_cfg_regs
    import rcfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data,
    output t_cfg             o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_MAX_CHANNELS: n_cfg.max_channels    = i_cfg_data[4:0];
                CFG_SNIFF_FRAMES: n_cfg.sniff_frames    = i_cfg_data[7:0];
                CFG_LOSS_TIMEOUT: n_cfg.loss_timeout_us = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_channels    <= MAX_CHANNELS_RST;
            r_cfg.sniff_frames    <= SNIFF_FRAMES_RST;
            r_cfg.loss_timeout_us <= LOSS_TIMEOUT_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/rcfd_slot_core.sv
// Per-slot decode logic and the format detection state.
`default_nettype none

module rcfd_slot_core
    import rcfd_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire logic     i_fire,
    input  wire t_in_item i_item,
    output t_out_item     o_result
);

    logic [15:0] r_mask_ten,  n_mask_ten;
    logic [15:0] r_mask_elv,  n_mask_elv;
    logic [7:0]  r_frames,    n_frames;
    logic [1:0]  r_fmt,       n_fmt;
    logic [31:0] r_prev_time, n_prev_time;
    logic [4:0]  r_run,       n_run;

    logic        first_slot;
    logic        last_slot;
    logic        slot_empty;
    logic [31:0] gap;
    logic        lost;
    logic [1:0]  fmt_eff;
    logic [15:0] mask_ten_upd;
    logic [15:0] mask_elv_upd;
    logic        hit_ten;
    logic        hit_elv;
    logic [3:0]  chan_raw;
    logic [15:0] val_ten;
    logic [15:0] val_elv;
    logic        chan_ok;
    logic [4:0]  chan_plus;

    assign first_slot = (i_item.slot_index == 3'd0);
    assign last_slot  = (i_item.slot_index == LAST_SLOT);
    assign slot_empty = (i_item.slot_word == EMPTY_SLOT);

    // A long silence before a frame drops a known format and restarts detection.
    assign gap     = i_item.start_stamp - r_prev_time;
    assign lost    = first_slot && (gap > i_cfg.loss_timeout_us) && (r_fmt != FMT_UNKNOWN);
    assign fmt_eff = lost ? FMT_UNKNOWN : r_fmt;

    assign mask_ten_upd = (lost ? 16'd0 : r_mask_ten) |
                          (slot_empty ? 16'd0 : (16'd1 << i_item.slot_word[13:10]));
    assign mask_elv_upd = (lost ? 16'd0 : r_mask_elv) |
                          (slot_empty ? 16'd0 : (16'd1 << i_item.slot_word[14:11]));
    assign hit_ten = is_known_mask(mask_ten_upd);
    assign hit_elv = is_known_mask(mask_elv_upd);

    assign chan_raw  = (fmt_eff == FMT_ELEVEN) ? i_item.slot_word[14:11]
                                               : i_item.slot_word[13:10];
    assign chan_ok   = !slot_empty && ({1'b0, chan_raw} < i_cfg.max_channels);
    assign chan_plus = {1'b0, chan_raw} + 5'd1;
    assign val_ten   = 16'({6'd0, i_item.slot_word[9:0]} << (VALUE_BITS - 10));
    assign val_elv   = 16'({5'd0, i_item.slot_word[10:0]} << (VALUE_BITS - 11));

    always_comb begin
        n_mask_ten  = lost ? 16'd0 : r_mask_ten;
        n_mask_elv  = lost ? 16'd0 : r_mask_elv;
        n_frames    = lost ? 8'd0 : r_frames;
        n_fmt       = fmt_eff;
        n_prev_time = first_slot ? i_item.start_stamp : r_prev_time;
        n_run       = first_slot ? 5'd0 : r_run;
        o_result    = '0;

        if (fmt_eff == FMT_UNKNOWN) begin
            n_mask_ten = mask_ten_upd;
            n_mask_elv = mask_elv_upd;
            if (last_slot) begin
                o_result.frame_done = 1'b1;
                if (n_frames < i_cfg.sniff_frames) begin
                    n_frames = n_frames + 8'd1;
                end else if (hit_elv && !hit_ten) begin
                    n_fmt = FMT_ELEVEN;
                end else if (hit_ten && !hit_elv) begin
                    n_fmt = FMT_TEN;
                end else begin
                    n_mask_ten = '0;
                    n_mask_elv = '0;
                    n_frames   = '0;
                end
            end
        end else begin
            if (chan_ok) begin
                if (chan_plus > n_run) begin
                    n_run = chan_plus;
                end
                o_result.slot_valid = 1'b1;
                o_result.out_value  = (fmt_eff == FMT_ELEVEN) ? val_elv : val_ten;
                case (chan_raw)
                    4'd0:    o_result.out_channel = 4'd2;
                    4'd1:    o_result.out_channel = 4'd0;
                    4'd2:    o_result.out_channel = 4'd1;
                    default: o_result.out_channel = chan_raw;
                endcase
            end
            if (last_slot) begin
                o_result.frame_done    = 1'b1;
                o_result.channel_count = (n_run == COUNT_ODD) ? COUNT_SHOW : n_run;
            end
        end
        o_result.format_state = n_fmt;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask_ten  <= '0;
            r_mask_elv  <= '0;
            r_frames    <= '0;
            r_fmt       <= FMT_UNKNOWN;
            r_prev_time <= '0;
            r_run       <= '0;
        end else if (i_fire) begin
            r_mask_ten  <= n_mask_ten;
            r_mask_elv  <= n_mask_elv;
            r_frames    <= n_frames;
            r_fmt       <= n_fmt;
            r_prev_time <= n_prev_time;
            r_run       <= n_run;
        end
    end

    // The format is only ever decided on the last slot of a frame.
    a_decide_on_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && r_fmt == FMT_UNKNOWN && n_fmt != FMT_UNKNOWN) |-> last_slot)
        else $error("format decided on a slot other than the last");

    // The running count never exceeds the widest channel space.
    a_run_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_run <= 5'd16)
        else $error("running channel count out of range");

    // While detecting, no slot yields a channel value.
    a_guess_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_fire && fmt_eff == FMT_UNKNOWN) |-> !o_result.slot_valid)
        else $error("channel value produced during format detection");

endmodule

`default_nettype wire

FILE: rtl/rc_frame_channel_decoder.sv
// Top level of the radio-control frame channel decoder: slot and result registers.
//
//  Channel  Direction  Handshake                 Payload
//  in       input      i_in_valid / o_in_stall   i_in_data  (t_in_item)
//  out      output     o_out_valid / i_out_stall o_out_data (t_out_item)
//  cfg      input      i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// A slot transfer is registered in the slot register, decoded combinationally and lands
// in the result register. One slot is accepted every cycle unless the output stalls;
// the limit is the single decode stage.
// Reset is synchronous and restores the register defaults and unknown format.
// A stalled output holds its result; the slot register then fills and stalls the input.
`default_nettype none

module rc_frame_channel_decoder
    import rcfd_pkg::*;
(
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire t_in_item    i_in_data,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output t_out_item        o_out_data,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);

    t_cfg      cfg;
    t_out_item core_result;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_data;

    logic      out_free;
    logic      s1_adv;
    logic      in_fire;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign s1_adv     = r_s1_valid && out_free;
    assign o_in_stall = r_s1_valid && !out_free;
    assign in_fire    = i_in_valid && !o_in_stall;

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

    rcfd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    rcfd_slot_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_fire   (s1_adv),
        .i_item   (r_s1_item),
        .o_result (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_fire) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_item <= i_in_data;
        end
        if (s1_adv) begin
            r_out_data <= core_result;
        end
    end

    // The input only stalls while a slot is held behind a stalled result.
    a_stall_needs_slot: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_s1_valid && r_out_valid && i_out_stall))
        else $error("input stalled with room in the pipeline");

    // A reported channel count is never thirteen.
    a_count_fold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.channel_count != COUNT_ODD))
        else $error("channel count of thirteen reported");

    // Only a last-slot result carries a channel count.
    a_count_on_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.frame_done) |-> (o_out_data.channel_count == 5'd0))
        else $error("channel count outside frame end");

endmodule

`default_nettype wire
